@@ design/mi3_pkg.sv @@
// shared constants and tables for the 3x3 matrix inverse pipeline
`default_nettype none

package mi3_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int TOL_WIDTH = 31;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1;

   localparam int LANES = 9;

   // csr map: one register, word addressed by a single index bit
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_BIT    = 2;
   localparam logic REG_TOLERANCE = 1'b0;

   // cofactor k = m[A]*m[B] - m[C]*m[D]
   localparam int COF_A [LANES] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int COF_B [LANES] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int COF_C [LANES] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int COF_D [LANES] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

   // determinant expands along row 0: m[j] * cofactor DET_COF[j]
   localparam int DET_COF [3] = '{0, 3, 6};

endpackage

`default_nettype wire

@@ design/mi3_channel_if.sv @@
// valid/ready channels for input matrices and result words
`default_nettype none

interface mi3_req_if #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface mi3_rsp_if #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic singular;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, output ready);
endinterface

`default_nettype wire

@@ design/mi3_front.sv @@
// products, cofactors and determinant, five pipeline stages
`default_nettype none

module mi3_front #(
   parameter  int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 2
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output      logic                                    in_ready,
   input  wire logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] in_m,
   output      logic                                    out_valid,
   input  wire logic                                    out_ready,
   output      logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] out_m,
   output      logic [mi3_pkg::LANES-1:0][CW-1:0]         out_cof,
   output      logic [DW-1:0]                           out_det
);

   localparam int E  = ELEM_WIDTH;
   localparam int PW = 2 * E;
   localparam int NS = 5;
   localparam int L  = mi3_pkg::LANES;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   go;

   // a stage loads when empty or when its word moves on
   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !v_ff[k] || go[k+1];
      v_in[0] = go[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NS; k++) v_in[k] = go[k] ? v_ff[k-1] : v_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = go[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: eighteen products
   logic signed [PW-1:0] pa_in [L], pb_in [L], pa_ff [L], pb_ff [L];
   logic [L-1:0][E-1:0]  m1_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         pa_in[i] = $signed(in_m[mi3_pkg::COF_A[i]]) * $signed(in_m[mi3_pkg::COF_B[i]]);
         pb_in[i] = $signed(in_m[mi3_pkg::COF_C[i]]) * $signed(in_m[mi3_pkg::COF_D[i]]);
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         m1_ff <= in_m;
      end
   end

   // stage 2: cofactors
   logic signed [CW-1:0] cof2_in [L], cof2_ff [L];
   logic [L-1:0][E-1:0]  m2_ff;

   always_comb begin
      for (int i = 0; i < L; i++) cof2_in[i] = CW'(pa_ff[i]) - CW'(pb_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         cof2_ff <= cof2_in;
         m2_ff   <= m1_ff;
      end
   end

   // stage 3: row 0 times cofactor, cofactor split into high and low halves
   logic signed [PW:0]   dl_in [3], dh_in [3], dl_ff [3], dh_ff [3];
   logic signed [CW-1:0] cof3_ff [L];
   logic [L-1:0][E-1:0]  m3_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dl_in[j] = $signed(m2_ff[j])
                  * $signed({1'b0, cof2_ff[mi3_pkg::DET_COF[j]][E-1:0]});
         dh_in[j] = $signed(m2_ff[j]) * $signed(cof2_ff[mi3_pkg::DET_COF[j]][CW-1:E]);
      end
   end

   always_ff @(posedge clock) begin
      if (go[2]) begin
         dl_ff   <= dl_in;
         dh_ff   <= dh_in;
         cof3_ff <= cof2_ff;
         m3_ff   <= m2_ff;
      end
   end

   // stage 4: recombine halves
   logic signed [DW-1:0] term_in [3], term_ff [3];
   logic signed [CW-1:0] cof4_ff [L];
   logic [L-1:0][E-1:0]  m4_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) term_in[j] = (DW'(dh_ff[j]) <<< E) + DW'(dl_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
         m4_ff   <= m3_ff;
      end
   end

   // stage 5: determinant
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] cof5_ff [L];
   logic [L-1:0][E-1:0]  m5_ff;

   always_ff @(posedge clock) begin
      if (go[4]) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         cof5_ff <= cof4_ff;
         m5_ff   <= m4_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < L; i++) out_cof[i] = cof5_ff[i];
   end

   assign out_m   = m5_ff;
   assign out_det = det_ff;

endmodule

`default_nettype wire

@@ design/mi3_prep.sv @@
// magnitudes, signs and singular test ahead of the divider, two stages
`default_nettype none

module mi3_prep #(
   parameter  int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter  int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 2,
   localparam int XW = (CW + 2 * FRAC_BITS > DW + ELEM_WIDTH) ?
                       CW + 2 * FRAC_BITS : DW + ELEM_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [mi3_pkg::TOL_WIDTH-1:0]           tol,
   input  wire logic                                    in_valid,
   output      logic                                    in_ready,
   input  wire logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] in_m,
   input  wire logic [mi3_pkg::LANES-1:0][CW-1:0]         in_cof,
   input  wire logic [DW-1:0]                           in_det,
   output      logic                                    out_valid,
   input  wire logic                                    out_ready,
   output      logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] out_m,
   output      logic [mi3_pkg::LANES-1:0][XW-1:0]         out_num,
   output      logic [XW-1:0]                           out_den,
   output      logic [mi3_pkg::LANES-1:0]               out_neg,
   output      logic                                    out_sing
);

   localparam int E    = ELEM_WIDTH;
   localparam int L    = mi3_pkg::LANES;
   localparam int NS   = 2;
   localparam int TSW  = mi3_pkg::TOL_WIDTH + 2 * FRAC_BITS;
   localparam int CMPW = (DW > TSW) ? DW : TSW;

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   go;

   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !v_ff[k] || go[k+1];
      v_in[0] = go[0] ? in_valid : v_ff[0];
      v_in[1] = go[1] ? v_ff[0] : v_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = go[0];
   assign out_valid = v_ff[NS-1];

   // stage 1: absolute values
   logic [L-1:0][CW-1:0] absc_in, absc_ff;
   logic [L-1:0]         negc_ff;
   logic [DW-1:0]        absd_ff;
   logic                 negd_ff;
   logic [L-1:0][E-1:0]  m1_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         absc_in[i] = in_cof[i][CW-1] ? (~in_cof[i] + 1'b1) : in_cof[i];
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         absc_ff <= absc_in;
         for (int i = 0; i < L; i++) negc_ff[i] <= in_cof[i][CW-1];
         absd_ff <= in_det[DW-1] ? (~in_det + 1'b1) : in_det;
         negd_ff <= in_det[DW-1];
         m1_ff   <= in_m;
      end
   end

   // stage 2: tolerance compare, numerator scaled by two fraction widths
   logic [L-1:0][XW-1:0] num_ff;
   logic [XW-1:0]        den_ff;
   logic [L-1:0]         neg_ff;
   logic                 sing_ff;
   logic [L-1:0][E-1:0]  m2_ff;

   always_ff @(posedge clock) begin
      if (go[1]) begin
         for (int i = 0; i < L; i++) num_ff[i] <= XW'(absc_ff[i]) << (2 * FRAC_BITS);
         den_ff  <= XW'(absd_ff);
         neg_ff  <= negc_ff ^ {L{negd_ff}};
         sing_ff <= CMPW'(absd_ff) <= (CMPW'(tol) << (2 * FRAC_BITS));
         m2_ff   <= m1_ff;
      end
   end

   assign out_m    = m2_ff;
   assign out_num  = num_ff;
   assign out_den  = den_ff;
   assign out_neg  = neg_ff;
   assign out_sing = sing_ff;

endmodule

`default_nettype wire

@@ design/mi3_divider.sv @@
// nine-lane restoring divider, one quotient bit per stage, with saturation
`default_nettype none

module mi3_divider #(
   parameter  int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter  int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 2,
   localparam int XW = (CW + 2 * FRAC_BITS > DW + ELEM_WIDTH) ?
                       CW + 2 * FRAC_BITS : DW + ELEM_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output      logic                                    in_ready,
   input  wire logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] in_m,
   input  wire logic [mi3_pkg::LANES-1:0][XW-1:0]         in_num,
   input  wire logic [XW-1:0]                           in_den,
   input  wire logic [mi3_pkg::LANES-1:0]               in_neg,
   input  wire logic                                    in_sing,
   output      logic                                    out_valid,
   input  wire logic                                    out_ready,
   output      logic [mi3_pkg::LANES-1:0][ELEM_WIDTH-1:0] out_r,
   output      logic                                    out_sing
);

   localparam int E  = ELEM_WIDTH;
   localparam int L  = mi3_pkg::LANES;
   localparam int NS = E + 2;
   localparam logic [E-1:0] HALF = {1'b1, {(E-1){1'b0}}};

   logic [NS-1:0] v_ff, v_in;
   logic [NS:0]   go;

   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) go[k] = !v_ff[k] || go[k+1];
      v_in[0] = go[0] ? in_valid : v_ff[0];
      for (int k = 1; k < NS; k++) v_in[k] = go[k] ? v_ff[k-1] : v_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = go[0];
   assign out_valid = v_ff[NS-1];

   logic [XW-1:0]       rem_ff  [E+1][L];
   logic [E-1:0]        q_ff    [E+1][L];
   logic [L-1:0]        ovf_ff  [E+1];
   logic [L-1:0]        neg_ff  [E+1];
   logic [XW-1:0]       den_ff  [E+1];
   logic                sing_ff [E+1];
   logic [L-1:0][E-1:0] m_ff    [E+1];

   // stage 0: a quotient of 2^E or more saturates whatever the sign
   always_ff @(posedge clock) begin
      if (go[0]) begin
         for (int i = 0; i < L; i++) begin
            rem_ff[0][i] <= in_num[i];
            q_ff[0][i]   <= '0;
            ovf_ff[0][i] <= in_num[i] >= (in_den << E);
         end
         neg_ff[0]  <= in_neg;
         den_ff[0]  <= in_den;
         sing_ff[0] <= in_sing;
         m_ff[0]    <= in_m;
      end
   end

   for (genvar k = 1; k <= E; k++) begin : g_step
      localparam int B = E - k;
      logic [XW-1:0] sh;
      logic [L-1:0]  take;

      always_comb begin
         sh = den_ff[k-1] << B;
         for (int i = 0; i < L; i++) take[i] = rem_ff[k-1][i] >= sh;
      end

      always_ff @(posedge clock) begin
         if (go[k]) begin
            for (int i = 0; i < L; i++) begin
               rem_ff[k][i] <= take[i] ? rem_ff[k-1][i] - sh : rem_ff[k-1][i];
               q_ff[k][i]   <= q_ff[k-1][i] | (E'(take[i]) << B);
            end
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
            m_ff[k]    <= m_ff[k-1];
         end
      end
   end

   // output word: clamp, apply sign, or pass the input through when singular
   logic [L-1:0][E-1:0] r_in, r_ff;
   logic                sing_out_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         if (sing_ff[E]) begin
            r_in[i] = m_ff[E][i];
         end else if (neg_ff[E][i]) begin
            if (ovf_ff[E][i] || q_ff[E][i] > HALF) r_in[i] = HALF;
            else                                   r_in[i] = ~q_ff[E][i] + 1'b1;
         end else begin
            if (ovf_ff[E][i] || q_ff[E][i][E-1]) r_in[i] = ~HALF;
            else                                 r_in[i] = q_ff[E][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[E+1]) begin
         r_ff        <= r_in;
         sing_out_ff <= sing_ff[E];
      end
   end

   assign out_r    = r_ff;
   assign out_sing = sing_out_ff;

endmodule

`default_nettype wire

@@ design/matrix_inverse_3x3_top.sv @@
// top level of the pipelined 3x3 fixed-point matrix inverse
`default_nettype none

// Inverts one row-major 3x3 signed fixed-point matrix per word through the
// adjugate: result = cofactor / determinant, truncated toward zero and
// clamped to the element range. When the determinant magnitude is at or
// below the tolerance register (same fixed-point format, offset 0x0), the
// input matrix comes back unchanged with singular set. A new matrix is
// accepted every clock cycle while results are taken. The pipeline has five
// stages for products, cofactors and the determinant, two for magnitudes
// and the tolerance test, and a restoring divider per element that resolves
// one quotient bit per stage plus an overflow stage and the output register.
// Each stage holds its word under back-pressure and empty stages close up.

module matrix_inverse_3x3_top #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mi3_req_if.sink                                  req_in,
   mi3_rsp_if.source                                rsp_out,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [mi3_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [mi3_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output      logic [mi3_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output      logic                                pready
);

   localparam int E  = ELEM_WIDTH;
   localparam int L  = mi3_pkg::LANES;
   localparam int CW = 2 * E + 1;
   localparam int DW = 3 * E + 2;
   localparam int XW = (CW + 2 * FRAC_BITS > DW + E) ? CW + 2 * FRAC_BITS : DW + E;
   localparam int TW = mi3_pkg::TOL_WIDTH;

   // tolerance register
   logic [TW-1:0] tol_ff;
   logic          tol_sel;

   assign tol_sel = paddr[mi3_pkg::CSR_IDX_BIT] == mi3_pkg::REG_TOLERANCE;
   assign pready  = 1'b1;
   assign prdata  = tol_sel ? mi3_pkg::CSR_DATA_WIDTH'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= mi3_pkg::TOL_RESET;
      end else if (psel && penable && pwrite && pready && tol_sel) begin
         tol_ff <= pwdata[TW-1:0];
      end
   end

   logic [L-1:0][E-1:0] req_m;
   assign req_m = {req_in.m22, req_in.m21, req_in.m20,
                   req_in.m12, req_in.m11, req_in.m10,
                   req_in.m02, req_in.m01, req_in.m00};

   logic                f_valid, f_ready;
   logic [L-1:0][E-1:0] f_m;
   logic [L-1:0][CW-1:0] f_cof;
   logic [DW-1:0]       f_det;

   mi3_front #(.ELEM_WIDTH(E)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_in.valid),
      .in_ready  (req_in.ready),
      .in_m      (req_m),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_m     (f_m),
      .out_cof   (f_cof),
      .out_det   (f_det)
   );

   logic                 p_valid, p_ready, p_sing;
   logic [L-1:0][E-1:0]  p_m;
   logic [L-1:0][XW-1:0] p_num;
   logic [XW-1:0]        p_den;
   logic [L-1:0]         p_neg;

   mi3_prep #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .tol       (tol_ff),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_m      (f_m),
      .in_cof    (f_cof),
      .in_det    (f_det),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_m     (p_m),
      .out_num   (p_num),
      .out_den   (p_den),
      .out_neg   (p_neg),
      .out_sing  (p_sing)
   );

   logic [L-1:0][E-1:0] d_r;

   mi3_divider #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_m      (p_m),
      .in_num    (p_num),
      .in_den    (p_den),
      .in_neg    (p_neg),
      .in_sing   (p_sing),
      .out_valid (rsp_out.valid),
      .out_ready (rsp_out.ready),
      .out_r     (d_r),
      .out_sing  (rsp_out.singular)
   );

   assign rsp_out.r00 = d_r[0];
   assign rsp_out.r01 = d_r[1];
   assign rsp_out.r02 = d_r[2];
   assign rsp_out.r10 = d_r[3];
   assign rsp_out.r11 = d_r[4];
   assign rsp_out.r12 = d_r[5];
   assign rsp_out.r20 = d_r[6];
   assign rsp_out.r21 = d_r[7];
   assign rsp_out.r22 = d_r[8];

endmodule

`default_nettype wire

@@ design/mi3_checker.sv @@
// port-level checks for the matrix inverse, bound to the top level
`default_nettype none

module mi3_checker #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [9*ELEM_WIDTH:0]               rsp_data,
   input wire logic                                psel,
   input wire logic                                penable,
   input wire logic                                pwrite,
   input wire logic [mi3_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input wire logic [mi3_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   input wire logic [mi3_pkg::CSR_DATA_WIDTH-1:0]  prdata
);

   localparam int TW = mi3_pkg::TOL_WIDTH;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("input not ready with empty pipeline");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped under back-pressure");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed under back-pressure");

   // tolerance written is read back on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite &&
       paddr[mi3_pkg::CSR_IDX_BIT] == mi3_pkg::REG_TOLERANCE)
      ##1 (paddr[mi3_pkg::CSR_IDX_BIT] == mi3_pkg::REG_TOLERANCE &&
           !(psel && penable && pwrite))
      |-> prdata == {1'b0, $past(pwdata[TW-1:0])})
      else $error("tolerance readback mismatch");

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind matrix_inverse_3x3_top mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_in.valid),
   .req_ready (req_in.ready),
   .rsp_valid (rsp_out.valid),
   .rsp_ready (rsp_out.ready),
   .rsp_data  ({rsp_out.singular, rsp_out.r22, rsp_out.r21, rsp_out.r20,
                rsp_out.r12, rsp_out.r11, rsp_out.r10,
                rsp_out.r02, rsp_out.r01, rsp_out.r00}),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);

`default_nettype wire

@@ bench/matrix_inverse_3x3_types.sv @@
// shared types for the matrix inverse bench
`timescale 1ns / 100ps

package mi3_bench_pkg;

   typedef logic signed [31:0] elem_type;

   typedef struct {
      elem_type m[9];
      bit       typed;
      elem_type r[9];
      bit       sing;
   } matrix_row_type;

   typedef struct {
      elem_type r[9];
      bit       sing;
   } inverse_type;

endpackage

@@ bench/matrix_inverse_3x3_top_tb.sv @@
// self-checking bench for the pipelined 3x3 matrix inverse
`timescale 1ns / 100ps

module matrix_inverse_3x3_top_tb;

   localparam mi3_bench_pkg::elem_type ONE  = 32'sh0001_0000;
   localparam mi3_bench_pkg::elem_type EMAX = 32'sh7fff_ffff;
   localparam mi3_bench_pkg::elem_type EMIN = 32'sh8000_0000;
   localparam logic [mi3_pkg::CSR_ADDR_WIDTH-1:0] ADDR_TOL    = 3'd0;
   localparam logic [mi3_pkg::CSR_ADDR_WIDTH-1:0] ADDR_UNUSED = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [mi3_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [mi3_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [mi3_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   mi3_req_if req_bus ();
   mi3_rsp_if rsp_bus ();

   matrix_inverse_3x3_top dut (
      .clock(clock), .reset(reset), .req_in(req_bus), .rsp_out(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [30:0]                tol_cfg = 31'd1;
   mi3_bench_pkg::inverse_type inverse_q[$];
   int          errors = 0, n_sent = 0, n_rsp = 0, n_sing = 0, n_sat = 0;
   bit          hold_go = 0, no_idle = 0, done = 0;
   int          idle_cycles = 0;

   // adjugate inverse at 128-bit width, truncated and clamped
   function automatic mi3_bench_pkg::inverse_type invert_predict(
         mi3_bench_pkg::elem_type m[9], logic [30:0] tol);
      logic signed [127:0] w[9], c[9], det;
      logic [127:0] mag, num, quo, lim;
      mi3_bench_pkg::inverse_type res;
      bit neg;
      for (int k = 0; k < 9; k++) w[k] = m[k];
      c[0] = w[4]*w[8] - w[7]*w[5];
      c[1] = w[7]*w[2] - w[1]*w[8];
      c[2] = w[1]*w[5] - w[4]*w[2];
      c[3] = w[6]*w[5] - w[3]*w[8];
      c[4] = w[0]*w[8] - w[6]*w[2];
      c[5] = w[3]*w[2] - w[0]*w[5];
      c[6] = w[3]*w[7] - w[6]*w[4];
      c[7] = w[6]*w[1] - w[0]*w[7];
      c[8] = w[0]*w[4] - w[3]*w[1];
      det = w[0]*c[0] + w[1]*c[3] + w[2]*c[6];
      mag = (det < 0) ? -det : det;
      if (mag <= ({97'd0, tol} << 32)) begin
         res.r = m;
         res.sing = 1'b1;
      end else begin
         res.sing = 1'b0;
         for (int k = 0; k < 9; k++) begin
            neg = (c[k] < 0) ^ (det < 0);
            num = ((c[k] < 0) ? -c[k] : c[k]);
            num = num << 32;
            quo = num / mag;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (quo > lim) quo = lim;
            res.r[k] = neg ? -quo[31:0] : quo[31:0];
         end
      end
      return res;
   endfunction

   task automatic csr_write(logic [mi3_pkg::CSR_ADDR_WIDTH-1:0] a, logic [31:0] d);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (a == ADDR_TOL) tol_cfg = d[30:0];
   endtask

   task automatic drain_then_write(logic [mi3_pkg::CSR_ADDR_WIDTH-1:0] a,
                                   logic [31:0] d);
      req_bus.valid <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_write(a, d);
   endtask

   task automatic send_matrix(mi3_bench_pkg::matrix_row_type row);
      mi3_bench_pkg::inverse_type want;
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.m00 <= row.m[0]; req_bus.m01 <= row.m[1]; req_bus.m02 <= row.m[2];
      req_bus.m10 <= row.m[3]; req_bus.m11 <= row.m[4]; req_bus.m12 <= row.m[5];
      req_bus.m20 <= row.m[6]; req_bus.m21 <= row.m[7]; req_bus.m22 <= row.m[8];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = invert_predict(row.m, tol_cfg);
      if (row.typed) begin
         want.r = row.r;
         want.sing = row.sing;
      end
      inverse_q.push_back(want);
      n_sent++;
      if (!no_idle && $urandom_range(0, 99) < 25) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic mi3_bench_pkg::elem_type rand_elem(int kind);
      mi3_bench_pkg::elem_type picks[6] = '{EMAX, EMIN, 0, 1, -1, ONE};
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 1 << 19) - (1 << 18);
         2: return picks[$urandom_range(0, 5)];
         default: return $urandom_range(0, 1 << 13) - (1 << 12);
      endcase
   endfunction

   function automatic mi3_bench_pkg::matrix_row_type rand_matrix();
      mi3_bench_pkg::matrix_row_type row;
      int pick = $urandom_range(0, 99);
      row.typed = 1'b0;
      if (pick < 40) begin
         foreach (row.m[k]) row.m[k] = rand_elem(1);
      end else if (pick < 65) begin
         foreach (row.m[k]) row.m[k] = rand_elem(0);
      end else if (pick < 80) begin
         // dependent rows, determinant exactly zero
         foreach (row.m[k]) row.m[k] = rand_elem(1);
         for (int j = 0; j < 3; j++) row.m[6+j] = row.m[j] + row.m[3+j];
      end else if (pick < 90) begin
         foreach (row.m[k]) row.m[k] = rand_elem(2);
      end else begin
         // small diagonal near the tolerance boundary
         foreach (row.m[k]) row.m[k] = ($urandom_range(0, 3) == 0) ? rand_elem(3) : 0;
         for (int j = 0; j < 3; j++)
            row.m[4*j] = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 1024);
      end
      return row;
   endfunction

   function automatic mi3_bench_pkg::matrix_row_type diag_row(
         mi3_bench_pkg::elem_type d, bit typed, mi3_bench_pkg::elem_type rd, bit sing);
      mi3_bench_pkg::matrix_row_type row;
      foreach (row.m[k]) begin
         row.m[k] = (k % 4 == 0) ? d : 0;
         row.r[k] = (k % 4 == 0) ? rd : 0;
      end
      row.typed = typed;
      row.sing = sing;
      return row;
   endfunction

   function automatic mi3_bench_pkg::matrix_row_type fill_row(mi3_bench_pkg::elem_type v);
      mi3_bench_pkg::matrix_row_type row;
      foreach (row.m[k]) begin
         row.m[k] = v;
         row.r[k] = v;
      end
      row.typed = 1'b1;
      row.sing = 1'b1;
      return row;
   endfunction

   task automatic random_phase(int count, bit pause_mid);
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) begin
            req_bus.valid <= 1'b0;
            while (inverse_q.size() != 0) @(posedge clock);
         end
         send_matrix(rand_matrix());
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      mi3_bench_pkg::elem_type got[9];
      mi3_bench_pkg::inverse_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.r00, rsp_bus.r01, rsp_bus.r02, rsp_bus.r10, rsp_bus.r11,
                 rsp_bus.r12, rsp_bus.r20, rsp_bus.r21, rsp_bus.r22};
         n_rsp++;
         if (inverse_q.size() == 0) begin
            $error("result word with no matrix outstanding");
            errors++;
         end else begin
            want = inverse_q.pop_front();
            if (want.sing) n_sing++;
            foreach (got[k]) begin
               if (!want.sing && (want.r[k] == EMAX || want.r[k] == EMIN)) n_sat++;
               if (got[k] !== want.r[k]) begin
                  $error("r%0d%0d: expected %h, got %h", k / 3, k % 3, want.r[k], got[k]);
                  errors++;
               end
            end
            if (rsp_bus.singular !== want.sing) begin
               $error("singular: expected %b, got %b", want.sing, rsp_bus.singular);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!done && idle_cycles > 20000) begin
         $display("watchdog: no word moved in %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      mi3_bench_pkg::matrix_row_type rows[$];
      mi3_bench_pkg::matrix_row_type row;
      req_bus.valid = 1'b0;
      {req_bus.m00, req_bus.m01, req_bus.m02, req_bus.m10, req_bus.m11,
       req_bus.m12, req_bus.m20, req_bus.m21, req_bus.m22} = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed matrices at the reset tolerance
      rows.push_back(diag_row(ONE, 1, ONE, 0));
      rows.push_back(diag_row(-ONE, 1, -ONE, 0));
      rows.push_back(diag_row(2 * ONE, 1, ONE / 2, 0));
      rows.push_back(fill_row(0));
      rows.push_back(fill_row(EMAX));
      rows.push_back(fill_row(EMIN));
      rows.push_back(diag_row(1, 0, 0, 0));
      rows.push_back(diag_row(EMAX, 0, 0, 0));
      rows.push_back(diag_row(EMIN, 0, 0, 0));
      rows.push_back(diag_row(32'sh0000_0100, 0, 0, 0));
      row = diag_row(ONE, 0, 0, 0);
      row.m[1] = EMAX; row.m[5] = EMIN; row.m[6] = -1;
      rows.push_back(row);
      for (int i = 0; i < 6; i++) rows.push_back(rand_matrix());
      foreach (rows[i]) send_matrix(rows[i]);

      // exact-zero tolerance, tiny determinants saturate
      drain_then_write(ADDR_TOL, 32'd0);
      drain_then_write(ADDR_UNUSED, 32'h7fff_ffff);
      send_matrix(diag_row(1, 0, 0, 0));
      send_matrix(diag_row(-1, 0, 0, 0));
      row = diag_row(1, 0, 0, 0);
      row.m[4] = -1;
      send_matrix(row);
      hold_go = 1;
      random_phase(180, 0);

      drain_then_write(ADDR_TOL, 32'h7fff_ffff);
      random_phase(170, 1);

      drain_then_write(ADDR_TOL, 32'h0001_0000);
      no_idle = 1;
      random_phase(120, 0);
      no_idle = 0;
      random_phase(60, 0);

      drain_then_write(ADDR_TOL, {1'b0, 31'($urandom)} >> $urandom_range(0, 30));
      random_phase(170, 0);

      drain_then_write(ADDR_TOL, 32'd1);
      random_phase(170, 0);
      req_bus.valid <= 1'b0;

      while (inverse_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      done = 1;
      $display("matrices sent %0d, results checked %0d, singular %0d, clamped elements %0d",
               n_sent, n_rsp, n_sing, n_sat);
      $display("tolerance settings: reset, zero, maximum, one unit, random, back to reset");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/mi3_pkg.sv
design/mi3_channel_if.sv
design/mi3_front.sv
design/mi3_prep.sv
design/mi3_divider.sv
design/matrix_inverse_3x3_top.sv
design/mi3_checker.sv
bench/matrix_inverse_3x3_types.sv
bench/matrix_inverse_3x3_top_tb.sv
